// ===== rtl/cmm_pkg.sv =====
`timescale 1ns / 1ps
package cmm_pkg;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 24;
    localparam int IDX_W          = 4;
    localparam int SITE_W         = 16;
    localparam int N_ELEM         = 9;
    localparam logic [IDX_W-1:0] LAST_IDX = 4'd8;

    typedef struct packed {
        logic             vld;
        logic [IDX_W-1:0] idx;
        logic             lst;
    } t_tag;
endpackage

// ===== rtl/cmm_term.sv =====
`timescale 1ns / 1ps
// One multiply cell: rounded product of two fixed-point values, registered.
module cmm_term import cmm_pkg::*; #(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic signed [DATA_WIDTH-1:0] i_a,
    input  logic signed [DATA_WIDTH-1:0] i_b,
    output logic signed [2*DATA_WIDTH-FRAC_BITS:0] o_p
);
    localparam int PW = 2*DATA_WIDTH;
    logic signed [PW-1:0] r_prod;
    logic signed [PW:0]   w_rnd;
    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end
    always_comb begin
        w_rnd = {r_prod[PW-1], r_prod} + ((PW+1)'(1) <<< (FRAC_BITS-1));
    end
    assign o_p = w_rnd[PW:FRAC_BITS];
endmodule

// ===== rtl/cmm_cell.sv =====
`timescale 1ns / 1ps
// Accumulating cell: adds its four rounded terms, as a complex product, to the partial sum it receives.
module cmm_cell import cmm_pkg::*; #(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic signed [DATA_WIDTH-1:0] i_ure,
    input  logic signed [DATA_WIDTH-1:0] i_uim,
    input  logic signed [DATA_WIDTH-1:0] i_mre,
    input  logic signed [DATA_WIDTH-1:0] i_mim,
    input  logic signed [2*DATA_WIDTH-FRAC_BITS+3:0] i_re,
    input  logic signed [2*DATA_WIDTH-FRAC_BITS+3:0] i_im,
    output logic signed [2*DATA_WIDTH-FRAC_BITS+3:0] o_re,
    output logic signed [2*DATA_WIDTH-FRAC_BITS+3:0] o_im
);
    localparam int TW = 2*DATA_WIDTH-FRAC_BITS+1;
    localparam int AW = TW+3;
    logic signed [TW-1:0] w_rr, w_ii, w_ri, w_ir;
    logic signed [AW-1:0] r_re_d, r_im_d, r_re, r_im;

    cmm_term #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_rr
        (.i_clk(i_clk), .i_a(i_ure), .i_b(i_mre), .o_p(w_rr));
    cmm_term #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_ii
        (.i_clk(i_clk), .i_a(i_uim), .i_b(i_mim), .o_p(w_ii));
    cmm_term #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_ri
        (.i_clk(i_clk), .i_a(i_ure), .i_b(i_mim), .o_p(w_ri));
    cmm_term #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_ir
        (.i_clk(i_clk), .i_a(i_uim), .i_b(i_mre), .o_p(w_ir));

    // delay incoming partial sum to line up with the product register
    always_ff @(posedge i_clk) begin
        r_re_d <= i_re;
        r_im_d <= i_im;
        r_re   <= r_re_d + AW'(w_rr) - AW'(w_ii);
        r_im   <= r_im_d + AW'(w_ri) + AW'(w_ir);
    end
    assign o_re = r_re;
    assign o_im = r_im;
endmodule

// ===== rtl/complex_3x3_matrix_multiply_top.sv =====
`timescale 1ns / 1ps
// Nine results follow once element 8 is taken, one per cycle.
// Throughput: one element per cycle while elements 0..7 load;
// busy holds after element 8 through the nine row/column issues and the
// drain of the three-cell chain. Synchronous active-low reset clears control
// and the site tag; the element stores are not reset. The receiver cannot stall results.
module complex_3x3_matrix_multiply_top import cmm_pkg::*; #(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [IDX_W-1:0]             i_element_index,
    input  logic signed [DATA_WIDTH-1:0] i_link_re,
    input  logic signed [DATA_WIDTH-1:0] i_link_im,
    input  logic signed [DATA_WIDTH-1:0] i_source_re,
    input  logic signed [DATA_WIDTH-1:0] i_source_im,
    input  logic [SITE_W-1:0]            i_dest_site,
    output logic                         o_valid,
    output logic [IDX_W-1:0]             o_out_index,
    output logic signed [DATA_WIDTH-1:0] o_product_re,
    output logic signed [DATA_WIDTH-1:0] o_product_im,
    output logic [SITE_W-1:0]            o_out_site,
    output logic                         o_last
);
    localparam int AW = 2*DATA_WIDTH-FRAC_BITS+4;
    localparam int LAT = 7; // cell k: 2 stages each, inputs registered skewed

    logic signed [DATA_WIDTH-1:0] r_ure [N_ELEM], r_uim [N_ELEM];
    logic signed [DATA_WIDTH-1:0] r_mre [N_ELEM], r_mim [N_ELEM];
    logic [SITE_W-1:0] r_site;
    logic              r_run;
    logic [1:0]        r_row, r_col;
    logic [3:0]        r_drain;
    t_tag              r_tag [LAT];
    logic              w_acc;

    assign w_acc = start && !busy;
    assign busy  = r_run || (r_drain != '0);

    always_ff @(posedge i_clk) begin
        if (w_acc && i_element_index <= LAST_IDX) begin
            r_ure[i_element_index] <= i_link_re;
            r_uim[i_element_index] <= i_link_im;
            r_mre[i_element_index] <= i_source_re;
            r_mim[i_element_index] <= i_source_im;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_site  <= '0;
            r_run   <= 1'b0;
            r_row   <= '0;
            r_col   <= '0;
            r_drain <= '0;
        end else begin
            if (w_acc && i_element_index == LAST_IDX) begin
                r_site <= i_dest_site;
                r_run  <= 1'b1;
                r_row  <= '0;
                r_col  <= '0;
            end else if (r_run) begin
                if (r_col == 2'd2) begin
                    r_col <= '0;
                    if (r_row == 2'd2) begin
                        r_run   <= 1'b0;
                        r_drain <= 4'(LAT);
                    end else begin
                        r_row <= r_row + 2'd1;
                    end
                end else begin
                    r_col <= r_col + 2'd1;
                end
            end else if (r_drain != '0) begin
                r_drain <= r_drain - 4'd1;
            end
        end
    end

    // operand skew: each cell reads its operands through its own skew register line, lined up with the partial sum
    logic signed [DATA_WIDTH-1:0] w_u_re [3], w_u_im [3], w_m_re [3], w_m_im [3];
    logic signed [AW-1:0] w_re [4], w_im [4];

    assign w_re[0] = '0;
    assign w_im[0] = '0;

    genvar k;
    generate
        for (k = 0; k < 3; k++) begin : g_cell
            logic signed [DATA_WIDTH-1:0] r_sk_ure [2*k+1], r_sk_uim [2*k+1];
            logic signed [DATA_WIDTH-1:0] r_sk_mre [2*k+1], r_sk_mim [2*k+1];
            always_comb begin
                w_u_re[k] = r_ure[4'(r_row)*4'd3 + 4'(k)];
                w_u_im[k] = r_uim[4'(r_row)*4'd3 + 4'(k)];
                w_m_re[k] = r_mre[4'(k)*4'd3 + 4'(r_col)];
                w_m_im[k] = r_mim[4'(k)*4'd3 + 4'(r_col)];
            end
            always_ff @(posedge i_clk) begin
                r_sk_ure[0] <= w_u_re[k];
                r_sk_uim[0] <= w_u_im[k];
                r_sk_mre[0] <= w_m_re[k];
                r_sk_mim[0] <= w_m_im[k];
                for (int s = 1; s < 2*k+1; s++) begin
                    r_sk_ure[s] <= r_sk_ure[s-1];
                    r_sk_uim[s] <= r_sk_uim[s-1];
                    r_sk_mre[s] <= r_sk_mre[s-1];
                    r_sk_mim[s] <= r_sk_mim[s-1];
                end
            end
            cmm_cell #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_cell (
                .i_clk(i_clk),
                .i_ure(r_sk_ure[2*k]), .i_uim(r_sk_uim[2*k]),
                .i_mre(r_sk_mre[2*k]), .i_mim(r_sk_mim[2*k]),
                .i_re(w_re[k]), .i_im(w_im[k]),
                .o_re(w_re[k+1]), .o_im(w_im[k+1])
            );
        end
    endgenerate

    // tag line: follows each issue through the skew reg and the three cells
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < LAT; s++) r_tag[s].vld <= 1'b0;
        end else begin
            r_tag[0].vld <= r_run;
            for (int s = 1; s < LAT; s++) r_tag[s].vld <= r_tag[s-1].vld;
        end
        r_tag[0].idx <= 4'(r_row)*4'd3 + 4'(r_col);
        r_tag[0].lst <= (r_row == 2'd2) && (r_col == 2'd2);
        for (int s = 1; s < LAT; s++) begin
            r_tag[s].idx <= r_tag[s-1].idx;
            r_tag[s].lst <= r_tag[s-1].lst;
        end
    end

    function automatic logic signed [DATA_WIDTH-1:0] f_sat(input logic signed [AW-1:0] v);
        logic signed [AW-1:0] hi, lo;
        hi = AW'({1'b0, {(DATA_WIDTH-1){1'b1}}});
        lo = ~hi;
        if (v > hi) return hi[DATA_WIDTH-1:0];
        else if (v < lo) return lo[DATA_WIDTH-1:0];
        else return v[DATA_WIDTH-1:0];
    endfunction

    assign o_valid      = r_tag[LAT-1].vld;
    assign o_out_index  = r_tag[LAT-1].idx;
    assign o_last       = r_tag[LAT-1].lst;
    assign o_out_site   = r_site;
    assign o_product_re = f_sat(w_re[3]);
    assign o_product_im = f_sat(w_im[3]);
endmodule
